FILE: rtl/core/bec_pkg.sv
package bec_pkg;

	// default button count
	localparam int NUM_BUTTONS_DEF = 8;

	// field widths
	localparam int ACTION_W = 2;
	localparam int BUTTON_W = 3;
	localparam int VEC_W    = 8;
	localparam int THR_W    = 15;
	localparam int CNT_W    = 16;

	// configuration port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// register reset values
	localparam logic [THR_W-1:0]    THR_RESET = THR_W'(15);
	localparam logic [BUTTON_W-1:0] WUP_RESET = BUTTON_W'(3);
	localparam logic [BUTTON_W-1:0] WDN_RESET = BUTTON_W'(4);

	// frame counters start one above the reset threshold
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(THR_RESET) + CNT_W'(1);

	typedef enum logic [ACTION_W-1:0] {
		ACT_DOWN = 2'd0,
		ACT_UP   = 2'd1,
		ACT_TICK = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_THR = 2'd0,
		REG_WUP = 2'd1,
		REG_WDN = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0]    thr;
		logic [BUTTON_W-1:0] wup;
		logic [BUTTON_W-1:0] wdn;
	} cfg_t;

	typedef struct packed {
		logic [VEC_W-1:0] pressed_bits;
		logic [VEC_W-1:0] triggered_bits;
		logic [VEC_W-1:0] released_bits;
		logic [VEC_W-1:0] dclicked_bits;
	} result_t;

endpackage

FILE: rtl/core/bec_if.sv
// event channel: down, up and tick beats
interface bec_in_if;
	logic                          valid;
	logic                          ready;
	logic [bec_pkg::ACTION_W-1:0]  action;
	logic [bec_pkg::BUTTON_W-1:0]  button;

	modport source (output valid, output action, output button, input ready);
	modport sink (input valid, input action, input button, output ready);
endinterface

// result channel: one beat per frame tick
interface bec_out_if;
	logic                       valid;
	logic                       ready;
	logic [bec_pkg::VEC_W-1:0]  pressed_bits;
	logic [bec_pkg::VEC_W-1:0]  triggered_bits;
	logic [bec_pkg::VEC_W-1:0]  released_bits;
	logic [bec_pkg::VEC_W-1:0]  dclicked_bits;

	modport source (output valid, output pressed_bits, output triggered_bits,
		output released_bits, output dclicked_bits, input ready);
	modport sink (input valid, input pressed_bits, input triggered_bits,
		input released_bits, input dclicked_bits, output ready);
endinterface

FILE: rtl/core/button_edge_and_double_click.sv
// channel  dir  beat                                       when
// evt      in   action, button                             down, up or frame tick
// res      out  pressed, triggered, released, dclicked     one per frame tick
// apb      in   click_window, wheel_up/down_button         register writes and reads
//
// One event beat is taken every cycle unless a tick waits on a stalled result.
// The rate is set by the input register feeding one pass of button logic into the result register.
// Reset clears the held vectors and flags and sets each frame counter to 16; no clearing pass.
// A stalled result holds only a tick in the input register; down and up beats still flow.
module button_edge_and_double_click #(
	parameter int NUM_BUTTONS = bec_pkg::NUM_BUTTONS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bec_in_if.sink                      evt,
	bec_out_if.source                   res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bec_pkg::ADDR_W-1:0]  paddr,
	input  logic [bec_pkg::DATA_W-1:0]  pwdata,
	output logic [bec_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	bec_pkg::cfg_t    cfg;
	bec_pkg::result_t result;
	bec_pkg::result_t res_q;

	logic                          valid_s1;
	logic [bec_pkg::ACTION_W-1:0]  action_s1;
	logic [bec_pkg::BUTTON_W-1:0]  button_s1;
	logic                          res_valid_q;
	logic                          is_tick_s1;
	logic                          slot_free;
	logic                          go;

	bec_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake: a tick waits only when the result register is full and stalled
	assign is_tick_s1 = (action_s1 == bec_pkg::ACT_TICK);
	assign slot_free  = !res_valid_q || res.ready;
	assign go         = valid_s1 && (!is_tick_s1 || slot_free);
	assign evt.ready  = !valid_s1 || go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			action_s1 <= evt.action;
			button_s1 <= evt.button;
		end
	end

	bec_core #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.action (action_s1),
		.button (button_s1),
		.cfg    (cfg),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go && is_tick_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && is_tick_s1) begin
			res_q <= result;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.pressed_bits   = res_q.pressed_bits;
	assign res.triggered_bits = res_q.triggered_bits;
	assign res.released_bits  = res_q.released_bits;
	assign res.dclicked_bits  = res_q.dclicked_bits;

`ifndef ASSERT_OFF
	// a processed tick always lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		(go && is_tick_s1) |=> res_valid_q)
		else $error("tick result not registered");

	// a button cannot be pressed and released in one frame
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((res_q.triggered_bits & res_q.released_bits) == '0))
		else $error("triggered and released overlap");

	// a double click only comes with a new press
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((res_q.dclicked_bits & ~res_q.triggered_bits) == '0))
		else $error("double click without press");

	// input stalls only behind a tick blocked by a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!evt.ready |-> (valid_s1 && is_tick_s1 && res_valid_q && !res.ready))
		else $error("input stalled without cause");
`endif

endmodule

FILE: rtl/core/bec_cfg.sv
module bec_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bec_pkg::ADDR_W-1:0]  paddr,
	input  logic [bec_pkg::DATA_W-1:0]  pwdata,
	output logic [bec_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output bec_pkg::cfg_t               cfg
);

	bec_pkg::cfg_t     cfg_q;
	bec_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = bec_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr <= bec_pkg::THR_RESET;
			cfg_q.wup <= bec_pkg::WUP_RESET;
			cfg_q.wdn <= bec_pkg::WDN_RESET;
		end else if (wr_en) begin
			case (idx)
				bec_pkg::REG_THR: cfg_q.thr <= pwdata[bec_pkg::THR_W-1:0];
				bec_pkg::REG_WUP: cfg_q.wup <= pwdata[bec_pkg::BUTTON_W-1:0];
				bec_pkg::REG_WDN: cfg_q.wdn <= pwdata[bec_pkg::BUTTON_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			bec_pkg::REG_THR: prdata = bec_pkg::DATA_W'(cfg_q.thr);
			bec_pkg::REG_WUP: prdata = bec_pkg::DATA_W'(cfg_q.wup);
			bec_pkg::REG_WDN: prdata = bec_pkg::DATA_W'(cfg_q.wdn);
			default:          prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/bec_core.sv
module bec_core #(
	parameter int NUM_BUTTONS = bec_pkg::NUM_BUTTONS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [bec_pkg::ACTION_W-1:0]  action,
	input  logic [bec_pkg::BUTTON_W-1:0]  button,
	input  bec_pkg::cfg_t                 cfg,
	output bec_pkg::result_t              result
);

	localparam int OUT_N = (NUM_BUTTONS < bec_pkg::VEC_W) ? NUM_BUTTONS : bec_pkg::VEC_W;

	logic [NUM_BUTTONS-1:0]                    held_now_q;
	logic [NUM_BUTTONS-1:0]                    held_before_q;
	logic [NUM_BUTTONS-1:0]                    flags_q;
	logic [NUM_BUTTONS-1:0][bec_pkg::CNT_W-1:0] cnt_q;

	logic [NUM_BUTTONS-1:0]                    held_now_d;
	logic [NUM_BUTTONS-1:0]                    held_before_d;
	logic [NUM_BUTTONS-1:0]                    flags_d;
	logic [NUM_BUTTONS-1:0][bec_pkg::CNT_W-1:0] cnt_d;

	logic [NUM_BUTTONS-1:0] btn_bit;
	logic [NUM_BUTTONS-1:0] wup_bit;
	logic [NUM_BUTTONS-1:0] wdn_bit;
	logic [NUM_BUTTONS-1:0] trig;
	logic [NUM_BUTTONS-1:0] rel;
	logic [NUM_BUTTONS-1:0] tick_flags;
	logic [NUM_BUTTONS-1:0][bec_pkg::CNT_W-1:0] tick_cnt;
	logic [bec_pkg::CNT_W-1:0] thr_ext;
	logic                      is_wheel;

	// one-hot button masks, zero for indices past the last button
	assign btn_bit = (32'(button) < NUM_BUTTONS) ? (NUM_BUTTONS'(1) << button) : '0;
	assign wup_bit = (32'(cfg.wup) < NUM_BUTTONS) ? (NUM_BUTTONS'(1) << cfg.wup) : '0;
	assign wdn_bit = (32'(cfg.wdn) < NUM_BUTTONS) ? (NUM_BUTTONS'(1) << cfg.wdn) : '0;
	assign is_wheel = (button == cfg.wup) || (button == cfg.wdn);
	assign thr_ext  = bec_pkg::CNT_W'(cfg.thr);

	// frame edges
	assign trig = held_now_q & ~held_before_q;
	assign rel  = held_before_q & ~held_now_q;

	// per-button double-click flag and frame counter on a tick
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (trig[i]) begin
				tick_flags[i] = flags_q[i] | (cnt_q[i] < thr_ext);
				tick_cnt[i]   = bec_pkg::CNT_W'(1);
			end else begin
				tick_flags[i] = 1'b0;
				tick_cnt[i]   = (cnt_q[i] <= thr_ext) ? (cnt_q[i] + bec_pkg::CNT_W'(1))
					: cnt_q[i];
			end
		end
	end

	// next state per action
	always_comb begin
		held_now_d    = held_now_q;
		held_before_d = held_before_q;
		flags_d       = flags_q;
		cnt_d         = cnt_q;
		case (action)
			bec_pkg::ACT_DOWN: held_now_d = held_now_q | btn_bit;
			bec_pkg::ACT_UP: begin
				if (!is_wheel) held_now_d = held_now_q & ~btn_bit;
			end
			bec_pkg::ACT_TICK: begin
				held_before_d = held_now_q;
				held_now_d    = held_now_q & ~wup_bit & ~wdn_bit;
				flags_d       = tick_flags;
				cnt_d         = tick_cnt;
			end
			default: ;
		endcase
	end

	// button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_now_q    <= '0;
			held_before_q <= '0;
			flags_q       <= '0;
			cnt_q         <= {NUM_BUTTONS{bec_pkg::CNT_RESET}};
		end else if (go) begin
			held_now_q    <= held_now_d;
			held_before_q <= held_before_d;
			flags_q       <= flags_d;
			cnt_q         <= cnt_d;
		end
	end

	// result of a tick, low buttons only
	assign result.pressed_bits   = bec_pkg::VEC_W'(held_now_q[OUT_N-1:0]);
	assign result.triggered_bits = bec_pkg::VEC_W'(trig[OUT_N-1:0]);
	assign result.released_bits  = bec_pkg::VEC_W'(rel[OUT_N-1:0]);
	assign result.dclicked_bits  = bec_pkg::VEC_W'(tick_flags[OUT_N-1:0]);

endmodule
